// ===== rtl/dftr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and constants for the dual fan tach to RPM converter.
// No dependencies.
package dftr_pkg;
	localparam int BYTE_W   = 8;
	localparam int LOW_KEEP = 5;
	localparam int CNT_W    = BYTE_W + LOW_KEEP;
	localparam int NUM_W    = 27;
	localparam int RPM_W    = 16;
	localparam int CMP_W    = CNT_W + RPM_W;
	localparam int NCH      = 2;

	localparam logic [CNT_W-1:0] CNT_NO_FAN = 13'd8191;
	localparam logic [NUM_W-1:0] NUM_RESET  = 27'd3932160;

	localparam int IN_DATA_W  = 4 * BYTE_W;
	localparam int IN_USER_W  = NCH;
	localparam int OUT_DATA_W = 3 * RPM_W;
	localparam int OUT_USER_W = 1;

	typedef logic [RPM_W-1:0] rpm_t;
endpackage

// ===== rtl/dual_fan_tach_to_rpm.sv =====
`timescale 1ns / 1ps
// Dual fan tach count to RPM converter, top level. Uses dftr_pkg, dftr_div_lane, dftr_merge.
// Pipeline: 17 divider lane stages (an input register, then one quotient bit per stage
// over 16 bits), plus the merge register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: valid bits cleared, rpm_numerator back to 3932160.
module dual_fan_tach_to_rpm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dftr_pkg::NUM_W-1:0]        cfg_data,       // rpm_numerator
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// ch1_count_high, ch1_count_low, ch2_count_high, ch2_count_low
	input  logic [dftr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic [dftr_pkg::IN_USER_W-1:0]    s_axis_tuser,   // ch1_read_ok, ch2_read_ok
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [dftr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // ch1_rpm, ch2_rpm, max_rpm
	output logic [dftr_pkg::OUT_USER_W-1:0]   m_axis_tuser    // no_response
);
	import dftr_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic             adv;
	logic             vld_s  [0:RPM_W];
	logic             none_s [0:RPM_W];
	rpm_t             rpm1, rpm2, ch1, ch2, mx;
	logic             nresp;

	assign cfg_ready     = 1'b1;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
		end else if (cfg_valid) begin
			num_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= RPM_W; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i <= RPM_W; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			none_s[0] <= !s_axis_tuser[0] && !s_axis_tuser[1];
			for (int i = 1; i <= RPM_W; i++) none_s[i] <= none_s[i-1];
		end
	end

	dftr_div_lane u_lane1 (
		.clk      (clk),
		.en       (adv),
		.num      (num_q),
		.cnt_high (s_axis_tdata[BYTE_W-1:0]),
		.cnt_low  (s_axis_tdata[2*BYTE_W-1:BYTE_W]),
		.read_ok  (s_axis_tuser[0]),
		.rpm      (rpm1)
	);

	dftr_div_lane u_lane2 (
		.clk      (clk),
		.en       (adv),
		.num      (num_q),
		.cnt_high (s_axis_tdata[3*BYTE_W-1:2*BYTE_W]),
		.cnt_low  (s_axis_tdata[4*BYTE_W-1:3*BYTE_W]),
		.read_ok  (s_axis_tuser[1]),
		.rpm      (rpm2)
	);

	dftr_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (vld_s[RPM_W]),
		.rpm1        (rpm1),
		.rpm2        (rpm2),
		.none        (none_s[RPM_W]),
		.out_valid   (m_axis_tvalid),
		.ch1_rpm     (ch1),
		.ch2_rpm     (ch2),
		.max_rpm     (mx),
		.no_response (nresp)
	);

	assign m_axis_tdata = {mx, ch2, ch1};
	assign m_axis_tuser = nresp;
endmodule

// ===== rtl/dftr_div_lane.sv =====
`timescale 1ns / 1ps
// One channel lane: count forming, range checks and a restoring divider,
// one quotient bit per pipeline stage. Depends on dftr_pkg.
module dftr_div_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dftr_pkg::NUM_W-1:0]    num,
	input  logic [dftr_pkg::BYTE_W-1:0]   cnt_high,
	input  logic [dftr_pkg::BYTE_W-1:0]   cnt_low,
	input  logic                          read_ok,
	output dftr_pkg::rpm_t                rpm
);
	import dftr_pkg::*;

	logic [CNT_W-1:0] cnt;
	logic             ovf;
	logic             kill0;

	logic [NUM_W-1:0] rem_s  [0:RPM_W-1];
	logic [CNT_W-1:0] div_s  [0:RPM_W-1];
	logic [RPM_W-1:0] quo_s  [0:RPM_W];
	logic             kill_s [0:RPM_W];

	assign cnt   = {cnt_high, cnt_low[BYTE_W-1 -: LOW_KEEP]};
	// quotient above the 16-bit range iff num >= cnt * 2^16
	assign ovf   = CMP_W'(num) >= {cnt, {RPM_W{1'b0}}};
	assign kill0 = !read_ok || (cnt == '0) || (cnt >= CNT_NO_FAN) || ovf;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			div_s[0]  <= cnt;
			quo_s[0]  <= '0;
			kill_s[0] <= kill0;
		end
	end

	for (genvar g = 1; g <= RPM_W; g++) begin : g_stage
		localparam int SH = RPM_W - g;
		logic [CMP_W-1:0] trial;
		logic [CMP_W-1:0] diff;
		logic             take;

		assign trial = CMP_W'(div_s[g-1]) << SH;
		assign take  = CMP_W'(rem_s[g-1]) >= trial;
		assign diff  = CMP_W'(rem_s[g-1]) - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g]  <= {quo_s[g-1][RPM_W-2:0], take};
				kill_s[g] <= kill_s[g-1];
			end
		end

		if (g < RPM_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= take ? diff[NUM_W-1:0] : rem_s[g-1];
					div_s[g] <= div_s[g-1];
				end
			end
		end
	end

	assign rpm = kill_s[RPM_W] ? '0 : quo_s[RPM_W];
endmodule

// ===== rtl/dftr_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: picks the larger channel speed (zero when neither channel responds) and holds the output register.
// Depends on dftr_pkg.
module dftr_merge (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  dftr_pkg::rpm_t rpm1,
	input  dftr_pkg::rpm_t rpm2,
	input  logic           none,
	output logic           out_valid,
	output dftr_pkg::rpm_t ch1_rpm,
	output dftr_pkg::rpm_t ch2_rpm,
	output dftr_pkg::rpm_t max_rpm,
	output logic           no_response
);
	import dftr_pkg::*;

	logic valid_q;
	rpm_t ch1_q, ch2_q, max_q;
	logic none_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch1_q  <= rpm1;
			ch2_q  <= rpm2;
			max_q  <= none ? '0 : ((rpm1 > rpm2) ? rpm1 : rpm2);
			none_q <= none;
		end
	end

	assign out_valid   = valid_q;
	assign ch1_rpm     = ch1_q;
	assign ch2_rpm     = ch2_q;
	assign max_rpm     = max_q;
	assign no_response = none_q;
endmodule

// ===== tb/tb_dual_fan_tach_to_rpm.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dual_fan_tach_to_rpm: directed and random tach readings over
// several numerator settings, with a built-in RPM predictor and in-order result check.
// Depends on dftr_pkg and the dual_fan_tach_to_rpm RTL.
module tb_dual_fan_tach_to_rpm;
	import dftr_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] c1_hi;
		logic [BYTE_W-1:0] c1_lo;
		logic              c1_ok;
		logic [BYTE_W-1:0] c2_hi;
		logic [BYTE_W-1:0] c2_lo;
		logic              c2_ok;
	} reading_t;

	typedef struct packed {
		rpm_t ch1;
		rpm_t ch2;
		rpm_t max_rpm;
		logic no_resp;
	} rpm_result_t;

	typedef struct {
		logic [BYTE_W-1:0] c1_hi, c1_lo;
		logic              c1_ok;
		logic [BYTE_W-1:0] c2_hi, c2_lo;
		logic              c2_ok;
		bit                fixed;
		rpm_t              w_ch1, w_ch2, w_max;
		logic              w_none;
	} vector_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	localparam int N_DIRECTED   = 14;
	localparam int N_PHASES     = 7;
	localparam int PER_PHASE    = 200;
	localparam int LONG_HOLD    = 150;
	localparam int SETTLE       = 40;
	localparam int MAX_COUNT_OK = 8190;

	// fixed rows hold the numerator at reset (3932160)
	vector_t directed [N_DIRECTED] = '{
		'{8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1},
		'{8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1},
		'{8'hFF, 8'hF8, 1'b1, 8'h10, 8'h00, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h00, 8'h07, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h00, 8'h08, 1'b1, 8'h01, 8'hE0, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'hFF, 8'hF8, 1'b0, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h01, 8'hE8, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'hFF, 8'hF0, 1'b1, 8'hFF, 8'hF7, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h55, 8'h55, 1'b0, 8'h03, 8'hC0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h80, 8'h00, 1'b1, 8'h00, 8'h10, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h55, 8'hAA, 1'b1, 8'hAA, 8'h55, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h12, 8'h37, 1'b1, 8'h12, 8'h37, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h7F, 8'hFF, 1'b1, 8'h01, 8'h00, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0},
		'{8'h08, 8'h00, 1'b1, 8'h1F, 8'h40, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [NUM_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	logic [NUM_W-1:0] rpm_numerator;
	rpm_result_t      rpm_expected [$];
	int               burst_left;
	int               readings_sent;
	int               results_checked = 0;
	int               mismatches = 0;
	int               settings_used;
	bit               hold_req = 1'b0;
	int               hold_left = 0;
	int               rx_left = 0;
	rx_mode_e         rx_mode = RX_OPEN;

	dual_fan_tach_to_rpm DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	function automatic rpm_t count_to_rpm(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
			logic ok, logic [NUM_W-1:0] num);
		logic [CNT_W-1:0] cnt;
		logic [NUM_W-1:0] q;
		cnt = {hi, lo[BYTE_W-1 -: LOW_KEEP]};
		if (!ok || cnt >= CNT_NO_FAN || cnt == '0)
			return '0;
		q = num / cnt;
		if (q > 65535)
			return '0;
		return q[RPM_W-1:0];
	endfunction

	function automatic rpm_result_t tach_to_rpm(reading_t r, logic [NUM_W-1:0] num);
		rpm_result_t p;
		p.ch1 = count_to_rpm(r.c1_hi, r.c1_lo, r.c1_ok, num);
		p.ch2 = count_to_rpm(r.c2_hi, r.c2_lo, r.c2_ok, num);
		p.no_resp = !r.c1_ok && !r.c2_ok;
		p.max_rpm = p.no_resp ? '0 : ((p.ch1 > p.ch2) ? p.ch1 : p.ch2);
		return p;
	endfunction

	// mostly counts that give a usable speed, plus the edges around them
	function automatic logic [CNT_W-1:0] pick_count(logic [NUM_W-1:0] num);
		int lo_ok;
		int sel;
		lo_ok = num / 65536 + 1;
		sel = $urandom_range(0, 9);
		if (sel <= 5)
			return CNT_W'($urandom_range(lo_ok, MAX_COUNT_OK));
		if (sel == 6)
			return CNT_W'($urandom_range(lo_ok > 2 ? lo_ok - 2 : 0, lo_ok + 2));
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return CNT_NO_FAN;
				2: return CNT_W'(1);
				default: return CNT_W'(MAX_COUNT_OK);
			endcase
		end
		return CNT_W'($urandom);
	endfunction

	function automatic reading_t random_reading(logic [NUM_W-1:0] num);
		reading_t r;
		logic [CNT_W-1:0] c1, c2;
		c1 = pick_count(num);
		c2 = pick_count(num);
		r.c1_hi = c1[CNT_W-1 -: BYTE_W];
		r.c1_lo = {c1[LOW_KEEP-1:0], 3'($urandom)};
		r.c1_ok = $urandom_range(0, 7) != 0;
		r.c2_hi = c2[CNT_W-1 -: BYTE_W];
		r.c2_lo = {c2[LOW_KEEP-1:0], 3'($urandom)};
		r.c2_ok = $urandom_range(0, 7) != 0;
		return r;
	endfunction

	task automatic send_reading(input reading_t r, input rpm_result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.c2_lo, r.c2_hi, r.c1_lo, r.c1_hi};
		s_axis_tuser  <= {r.c2_ok, r.c1_ok};
		do @(posedge clk); while (!s_axis_tready);
		rpm_expected.push_back(want);
		readings_sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (rpm_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_numerator(input logic [NUM_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		rpm_numerator = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input rpm_t want, input rpm_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// receiver: changing stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:     m_axis_tready <= 1'b1;
				RX_RANDOM:   m_axis_tready <= $urandom_range(0, 3) != 0;
				RX_SPARSE:   m_axis_tready <= $urandom_range(0, 9) < 3;
				RX_PERIODIC: m_axis_tready <= (rx_left % 3) == 0;
				default:     m_axis_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		rpm_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rpm_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tdata=%h tuser=%b",
					$time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = rpm_expected.pop_front();
				check_field("ch1_rpm", want.ch1, m_axis_tdata[RPM_W-1:0]);
				check_field("ch2_rpm", want.ch2, m_axis_tdata[2*RPM_W-1:RPM_W]);
				check_field("max_rpm", want.max_rpm, m_axis_tdata[3*RPM_W-1:2*RPM_W]);
				check_field("no_response", RPM_W'(want.no_resp), RPM_W'(m_axis_tuser[0]));
				results_checked++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		reading_t         r;
		rpm_result_t      want;
		logic [NUM_W-1:0] setting;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		burst_left    = 0;
		readings_sent = 0;
		settings_used = 1;
		rpm_numerator = NUM_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			r = '{directed[i].c1_hi, directed[i].c1_lo, directed[i].c1_ok,
				directed[i].c2_hi, directed[i].c2_lo, directed[i].c2_ok};
			if (directed[i].fixed)
				want = '{directed[i].w_ch1, directed[i].w_ch2, directed[i].w_max,
					directed[i].w_none};
			else
				want = tach_to_rpm(r, rpm_numerator);
			send_reading(r, want);
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			if (phase > 0) begin
				case (phase)
					1: setting = '1;
					2: setting = '0;
					3: setting = NUM_W'(1);
					4: setting = NUM_W'(65535);
					5: setting = NUM_W'(6000000);
					default: setting = NUM_W'($urandom);
				endcase
				drain();
				write_numerator(setting);
			end
			for (int i = 0; i < PER_PHASE; i++) begin
				if (phase == 1 && i == 40)
					hold_req = 1'b1;
				if (phase == 5 && i == 100)
					drain();
				r = random_reading(rpm_numerator);
				send_reading(r, tach_to_rpm(r, rpm_numerator));
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d tach readings over %0d numerator settings (zero and full scale",
			readings_sent, settings_used);
		$display("included); %0d results compared, %0d mismatches.", results_checked,
			mismatches);
		if (mismatches == 0 && rpm_expected.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
